### rtl/core/arp_pkg.sv
// shared constants, types and helper functions for the address range to prefix unit
`timescale 1ns / 1ps
`default_nettype none
package arp_pkg;

    localparam int ADDRESS_BITS_DEF = 32;
    localparam int FIELD_BITS       = 32;
    localparam int LENGTH_BITS      = 6;
    localparam int INDEX_BITS       = $clog2(FIELD_BITS);
    localparam int QUEUE_DEPTH      = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [FIELD_BITS-1:0] reverse_bits(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < FIELD_BITS; i++) begin
            r[i] = v[FIELD_BITS-1-i];
        end
        return r;
    endfunction

    // one-hot block size: lower of the address alignment and the top bit of the count
    function automatic logic [FIELD_BITS-1:0] block_size(input logic [FIELD_BITS-1:0] addr,
                                                        input logic [FIELD_BITS-1:0] left);
        logic [FIELD_BITS-1:0] lo_addr;
        logic [FIELD_BITS-1:0] rev_left;
        logic [FIELD_BITS-1:0] hi_left;
        lo_addr  = addr & (~addr + FIELD_BITS'(1));
        rev_left = reverse_bits(left);
        hi_left  = reverse_bits(rev_left & (~rev_left + FIELD_BITS'(1)));
        return (lo_addr == '0 || hi_left < lo_addr) ? hi_left : lo_addr;
    endfunction

    function automatic logic [INDEX_BITS-1:0] onehot_index(input logic [FIELD_BITS-1:0] v);
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (v[i]) begin
                idx = idx | INDEX_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

### rtl/core/arp_front.sv
// front stage: takes a request, masks the address, clamps the count and queues it; a zero count is dropped
`timescale 1ns / 1ps
`default_nettype none
module arp_front #(
    parameter int ADDRESS_BITS = arp_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [arp_pkg::FIELD_BITS-1:0]               i_start_address,
    input  logic [arp_pkg::FIELD_BITS-1:0]               i_address_count,
    input  arp_pkg::t_queue_status                       i_queue,
    output logic                                         o_busy,
    output logic                                         o_push,
    output logic [ADDRESS_BITS+arp_pkg::FIELD_BITS-1:0]  o_push_data
);
    import arp_pkg::*;

    localparam int CW = (ADDRESS_BITS > FIELD_BITS) ? ADDRESS_BITS : FIELD_BITS;

    logic                    r_vld;
    logic                    n_vld;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [FIELD_BITS-1:0]   r_count;
    logic                    drop;
    logic                    accept;
    logic                    advance;
    logic [ADDRESS_BITS-1:0] room;
    logic [FIELD_BITS-1:0]   cnt_m1;
    logic [FIELD_BITS-1:0]   left;

    assign drop    = (r_count == '0);
    assign o_busy  = r_vld && !drop && i_queue.full;
    assign accept  = i_start && !o_busy;
    assign advance = r_vld && (drop || !i_queue.full);
    assign room    = ~r_addr;
    assign cnt_m1  = r_count - FIELD_BITS'(1);

    // clamp at the top of the address space
    always_comb begin
        if (CW'(cnt_m1) > CW'(room)) begin
            left = FIELD_BITS'(room) + FIELD_BITS'(1);
        end else begin
            left = r_count;
        end
    end

    assign o_push      = r_vld && !drop && !i_queue.full;
    assign o_push_data = {r_addr, left};

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (advance) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= ADDRESS_BITS'(i_start_address);
            r_count <= i_address_count;
        end
    end

endmodule
`default_nettype wire

### rtl/core/arp_queue.sv
// short request queue between the front and back stages
`timescale 1ns / 1ps
`default_nettype none
module arp_queue #(
    parameter int WIDTH = arp_pkg::ADDRESS_BITS_DEF + arp_pkg::FIELD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_push_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_pop_data,
    output arp_pkg::t_queue_status o_status
);
    import arp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;

    assign o_status.full  = (r_fill == FW'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + FW'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/arp_back.sv
// back stage: walks one request and emits one aligned prefix per cycle
`timescale 1ns / 1ps
`default_nettype none
module arp_back #(
    parameter int ADDRESS_BITS = arp_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  arp_pkg::t_queue_status                       i_queue,
    input  logic [ADDRESS_BITS+arp_pkg::FIELD_BITS-1:0]  i_pop_data,
    output logic                                         o_pop,
    output logic                                         o_prefix_valid,
    output logic [arp_pkg::FIELD_BITS-1:0]               o_prefix_base,
    output logic [arp_pkg::LENGTH_BITS-1:0]              o_prefix_length,
    output logic                                         o_last_prefix
);
    import arp_pkg::*;

    logic                    r_act;
    logic                    n_act;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [ADDRESS_BITS-1:0] n_addr;
    logic [FIELD_BITS-1:0]   r_left;
    logic [FIELD_BITS-1:0]   n_left;
    logic [FIELD_BITS-1:0]   size;
    logic [INDEX_BITS-1:0]   order;
    logic                    last;
    logic                    load;
    logic                    r_valid;
    logic [FIELD_BITS-1:0]   r_base;
    logic [LENGTH_BITS-1:0]  r_length;
    logic                    r_last;

    assign size  = block_size(FIELD_BITS'(r_addr), r_left);
    assign order = onehot_index(size);
    assign last  = (r_left == size);
    assign load  = (!r_act || last) && !i_queue.empty;
    assign o_pop = load;

    always_comb begin
        if (load) begin
            n_act  = 1'b1;
            n_addr = i_pop_data[ADDRESS_BITS+FIELD_BITS-1:FIELD_BITS];
            n_left = i_pop_data[FIELD_BITS-1:0];
        end else begin
            n_act  = r_act && !last;
            n_addr = r_addr + ADDRESS_BITS'(size);
            n_left = r_left - size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_act   <= n_act;
            r_valid <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        if (r_act) begin
            r_base   <= FIELD_BITS'(r_addr);
            r_length <= LENGTH_BITS'(7'(ADDRESS_BITS) - 7'(order));
            r_last   <= last;
        end
    end

    assign o_prefix_valid  = r_valid;
    assign o_prefix_base   = r_base;
    assign o_prefix_length = r_length;
    assign o_last_prefix   = r_last;

endmodule
`default_nettype wire

### rtl/core/address_range_to_prefixes_unit.sv
// top level of the address range to prefix unit
`timescale 1ns / 1ps
`default_nettype none
// A request (start address, address count) is taken when start is high and busy is low.
// The unit answers with the shortest ascending run of aligned prefixes covering the range,
// clamped at the top of the address space; a zero count yields no prefix. The back stage
// emits one prefix per clock cycle while it walks a request, and a request yields 1 to 62
// prefixes; the first passes the front register, the queue and the back stage registers.
// A front stage and a two-entry queue let further requests be taken while the back stage
// walks a range; busy rises only when both are full. Each prefix is shown for exactly one
// cycle with o_prefix_valid high and must be taken then: the receiver cannot stall it.
module address_range_to_prefixes_unit #(
    parameter int ADDRESS_BITS = arp_pkg::ADDRESS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [arp_pkg::FIELD_BITS-1:0]  i_start_address,
    input  logic [arp_pkg::FIELD_BITS-1:0]  i_address_count,
    output logic                            o_prefix_valid,
    output logic [arp_pkg::FIELD_BITS-1:0]  o_prefix_base,
    output logic [arp_pkg::LENGTH_BITS-1:0] o_prefix_length,
    output logic                            o_last_prefix
);
    import arp_pkg::*;

    localparam int QW = ADDRESS_BITS + FIELD_BITS;

    t_queue_status queue_status;
    logic          push;
    logic [QW-1:0] push_data;
    logic          pop;
    logic [QW-1:0] pop_data;

    arp_front #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_start_address(i_start_address),
        .i_address_count(i_address_count),
        .i_queue        (queue_status),
        .o_busy         (busy),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    arp_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_pop_data (pop_data),
        .o_status   (queue_status)
    );

    arp_back #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue        (queue_status),
        .i_pop_data     (pop_data),
        .o_pop          (pop),
        .o_prefix_valid (o_prefix_valid),
        .o_prefix_base  (o_prefix_base),
        .o_prefix_length(o_prefix_length),
        .o_last_prefix  (o_last_prefix)
    );

endmodule
`default_nettype wire

### rtl/core/arp_checker.sv
// port-level checker for the address range to prefix unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
module arp_checker #(
    parameter int ADDRESS_BITS = arp_pkg::ADDRESS_BITS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            busy,
    input wire logic                            o_prefix_valid,
    input wire logic [arp_pkg::FIELD_BITS-1:0]  o_prefix_base,
    input wire logic [arp_pkg::LENGTH_BITS-1:0] o_prefix_length,
    input wire logic                            o_last_prefix
);
    import arp_pkg::*;

    logic                  size_known;
    logic [FIELD_BITS-1:0] blk;

    // block size from the prefix length, where it fits the base field
    always_comb begin
        size_known = (int'(o_prefix_length) <= ADDRESS_BITS) &&
                     (ADDRESS_BITS - int'(o_prefix_length) < FIELD_BITS);
        blk = size_known ? (FIELD_BITS'(1) << (ADDRESS_BITS - int'(o_prefix_length)))
                         : FIELD_BITS'(1);
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_prefix_valid)
        else $error("busy or result strobe after reset");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prefix_valid && size_known |-> (o_prefix_base & (blk - FIELD_BITS'(1))) == '0)
        else $error("prefix base not aligned to its block");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prefix_valid && !o_last_prefix |=> o_prefix_valid)
        else $error("gap inside a request");

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prefix_valid && !o_last_prefix && size_known |=>
            o_prefix_base == $past(o_prefix_base + blk))
        else $error("prefixes of a request not contiguous");

endmodule

bind address_range_to_prefixes_unit arp_checker #(
    .ADDRESS_BITS(ADDRESS_BITS)
) u_arp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_prefix_valid (o_prefix_valid),
    .o_prefix_base  (o_prefix_base),
    .o_prefix_length(o_prefix_length),
    .o_last_prefix  (o_last_prefix)
);
`default_nettype wire

### sim/address_range_to_prefixes_unit_tb.sv
// testbench for the address range to prefix unit: directed and random ranges
`timescale 1ns / 1ps
module address_range_to_prefixes_unit_tb;

    import arp_pkg::*;

    localparam int MAX_PREFIXES  = 62;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 120;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [FIELD_BITS-1:0]  base;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_prefix;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [FIELD_BITS-1:0]  i_start_address;
    logic [FIELD_BITS-1:0]  i_address_count;
    logic                   o_prefix_valid;
    logic [FIELD_BITS-1:0]  o_prefix_base;
    logic [LENGTH_BITS-1:0] o_prefix_length;
    logic                   o_last_prefix;

    t_prefix pending_prefixes[$];
    t_prefix expected_prefix;
    int      fail_count;
    int      quiet_cycles;

    address_range_to_prefixes_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_address (i_start_address),
        .i_address_count (i_address_count),
        .o_prefix_valid  (o_prefix_valid),
        .o_prefix_base   (o_prefix_base),
        .o_prefix_length (o_prefix_length),
        .o_last_prefix   (o_last_prefix)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // aligned prefixes covering [first_addr, first_addr + count), clamped at the top
    function automatic void predict_prefixes(input logic [FIELD_BITS-1:0] first_addr,
                                             input logic [FIELD_BITS-1:0] count);
        logic [FIELD_BITS-1:0] addr;
        logic [FIELD_BITS:0]   left;
        logic [FIELD_BITS:0]   room;
        logic [FIELD_BITS:0]   size;
        int                    order;
        int                    emitted;
        t_prefix               p;
        addr    = first_addr;
        left    = {1'b0, count};
        room    = {1'b0, {FIELD_BITS{1'b1}}} - {1'b0, addr} + 1;
        emitted = 0;
        if (left > room) begin
            left = room;
        end
        while (left != 0 && emitted < MAX_PREFIXES) begin
            if (addr == '0) begin
                order = FIELD_BITS;
            end else begin
                order = 0;
                while (!addr[order]) order++;
            end
            while (order > 0 && ((FIELD_BITS+1)'(1) << order) > left) order--;
            size     = (FIELD_BITS+1)'(1) << order;
            p.base   = addr;
            p.length = LENGTH_BITS'(FIELD_BITS - order);
            p.last   = (left == size) || (emitted + 1 == MAX_PREFIXES);
            pending_prefixes = {pending_prefixes, p};
            emitted++;
            addr = addr + size[FIELD_BITS-1:0];
            left = left - size;
        end
    endfunction

    // called in the time step of a rising edge; returns in the step of the accepting edge
    task automatic send_range(input logic [FIELD_BITS-1:0] addr,
                              input logic [FIELD_BITS-1:0] count);
        start           <= 1'b1;
        i_start_address <= addr;
        i_address_count <= count;
        do @(posedge i_clk); while (busy);
        predict_prefixes(addr, count);
    endtask

    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic random_range(output logic [FIELD_BITS-1:0] addr,
                                output logic [FIELD_BITS-1:0] count);
        int pick;
        int sh;
        pick = $urandom_range(0, 99);
        sh   = $urandom_range(0, 31);
        addr = $urandom;
        if (pick < 30) begin
            count = $urandom_range(1, 64);
        end else if (pick < 50) begin
            addr  = (addr >> sh) << sh;
            count = FIELD_BITS'($urandom) >> $urandom_range(0, 31);
            if (count == '0) count = 1;
        end else if (pick < 65) begin
            count = $urandom;
            if (count == '0) count = 1;
        end else if (pick < 80) begin
            addr  = {FIELD_BITS{1'b1}} - FIELD_BITS'($urandom_range(0, 4095));
            count = FIELD_BITS'($urandom) >> $urandom_range(0, 24);
            if (count == '0) count = 1;
        end else if (pick < 96) begin
            count = FIELD_BITS'(1) << sh;
            if ($urandom_range(0, 1) == 1 && count != 1) count = count - 1;
        end else begin
            count = '0;
        end
    endtask

    task automatic run_random(input int idle_pct);
        logic [FIELD_BITS-1:0] addr;
        logic [FIELD_BITS-1:0] count;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            random_range(addr, count);
            send_range(addr, count);
            sender_gap(idle_pct);
        end
    endtask

    task automatic test_range_extremes;
        send_range(32'h0000_0000, 32'h0000_0001);
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_range(32'h0000_0001, 32'hFFFF_FFFE);
        send_range(32'hFFFF_FFFF, 32'h0000_0001);
        send_range(32'hAAAA_AAAA, 32'h5555_5555);
        send_range(32'h5555_5555, 32'h2AAA_AAAA);
        send_range(32'h0000_0100, 32'h0000_0100);
        send_range(32'h0A00_0000, 32'h0100_0000);
        send_range(32'h0000_0003, 32'h0000_0005);
        send_range(32'h8000_0000, 32'h8000_0000);
        send_range(32'h7FFF_FFFF, 32'h0000_0002);
    endtask

    task automatic test_top_clamp;
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_range(32'h8000_0000, 32'hFFFF_FFFF);
        send_range(32'hFFFF_FF00, 32'h0000_0101);
        send_range(32'hFFFF_FFFE, 32'h0000_0003);
        send_range(32'h1234_5679, 32'hF000_0000);
        send_range(32'hFFFF_FF00, 32'h0000_0100);
    endtask

    task automatic test_zero_count;
        send_range(32'h0000_0000, 32'h0000_0000);
        send_range(32'h1234_5678, 32'h0000_0000);
        send_range(32'hFFFF_FFFF, 32'h0000_0000);
        send_range(32'h0000_0010, 32'h0000_0001);
    endtask

    task automatic test_random_back_to_back;
        run_random(0);
    endtask

    task automatic test_random_sparse;
        run_random(60);
    endtask

    task automatic test_random_light_gaps;
        run_random(11);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_prefix_valid) begin
            if (pending_prefixes.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected prefix base=%h len=%0d last=%b",
                             o_prefix_base, o_prefix_length, o_last_prefix);
                end
            end else begin
                expected_prefix = pending_prefixes.pop_front();
                if (o_prefix_base !== expected_prefix.base ||
                    o_prefix_length !== expected_prefix.length ||
                    o_last_prefix !== expected_prefix.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 expected_prefix.base, expected_prefix.length,
                                 expected_prefix.last, o_prefix_base, o_prefix_length,
                                 o_last_prefix);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_prefix_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("address_range_to_prefixes_unit_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        fail_count      = 0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_start_address = '0;
        i_address_count = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_extremes();
        test_top_clamp();
        test_zero_count();
        test_random_back_to_back();
        test_random_sparse();
        test_random_light_gaps();

        start <= 1'b0;
        while (pending_prefixes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_prefixes.size() == 0) begin
            $display("address_range_to_prefixes_unit_tb: clean");
        end else begin
            $display("address_range_to_prefixes_unit_tb: errors");
        end
        $finish;
    end

endmodule
